// File: src/trgr_pkg.sv
// Shared types, constants and the font table for the text row glyph renderer.
`default_nettype none

package trgr_pkg;

    localparam int ROW_WIDTH  = 128;
    localparam int GLYPH_COLS = 5;
    localparam int CELL_COLS  = 6;
    localparam int POS_W      = 8;
    localparam int IDX_W      = 7;
    localparam int CNT_W      = 3;
    localparam int KIND_CHAR  = 0;
    localparam int KIND_NEWLINE = 1;

    typedef logic [0:GLYPH_COLS-1][7:0] t_glyph;

    typedef struct packed {
        logic [IDX_W-1:0] base;
        t_glyph           cols;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    function automatic t_glyph font_lookup(input logic [7:0] code);
        logic [7:0] c;
        t_glyph     g;
        c = code;
        if (code inside {[8'h61:8'h7A]}) begin
            c = code - 8'd32;
        end
        case (c)
            8'h30: g = {8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E};
            8'h31: g = {8'h00, 8'h42, 8'h7F, 8'h40, 8'h00};
            8'h32: g = {8'h42, 8'h61, 8'h51, 8'h49, 8'h46};
            8'h33: g = {8'h21, 8'h41, 8'h45, 8'h4B, 8'h31};
            8'h34: g = {8'h18, 8'h14, 8'h12, 8'h7F, 8'h10};
            8'h35: g = {8'h27, 8'h45, 8'h45, 8'h45, 8'h39};
            8'h36: g = {8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30};
            8'h37: g = {8'h01, 8'h71, 8'h09, 8'h05, 8'h03};
            8'h38: g = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
            8'h39: g = {8'h06, 8'h49, 8'h49, 8'h29, 8'h1E};
            8'h41: g = {8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E};
            8'h42: g = {8'h7F, 8'h49, 8'h49, 8'h49, 8'h36};
            8'h43: g = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h22};
            8'h44: g = {8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C};
            8'h45: g = {8'h7F, 8'h49, 8'h49, 8'h49, 8'h41};
            8'h46: g = {8'h7F, 8'h09, 8'h09, 8'h09, 8'h01};
            8'h47: g = {8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A};
            8'h48: g = {8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F};
            8'h49: g = {8'h00, 8'h41, 8'h7F, 8'h41, 8'h00};
            8'h4A: g = {8'h20, 8'h40, 8'h41, 8'h3F, 8'h01};
            8'h4B: g = {8'h7F, 8'h08, 8'h14, 8'h22, 8'h41};
            8'h4C: g = {8'h7F, 8'h40, 8'h40, 8'h40, 8'h40};
            8'h4D: g = {8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F};
            8'h4E: g = {8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F};
            8'h4F: g = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E};
            8'h50: g = {8'h7F, 8'h09, 8'h09, 8'h09, 8'h06};
            8'h51: g = {8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E};
            8'h52: g = {8'h7F, 8'h09, 8'h19, 8'h29, 8'h46};
            8'h53: g = {8'h46, 8'h49, 8'h49, 8'h49, 8'h31};
            8'h54: g = {8'h01, 8'h01, 8'h7F, 8'h01, 8'h01};
            8'h55: g = {8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F};
            8'h56: g = {8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F};
            8'h57: g = {8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F};
            8'h58: g = {8'h63, 8'h14, 8'h08, 8'h14, 8'h63};
            8'h59: g = {8'h07, 8'h08, 8'h70, 8'h08, 8'h07};
            8'h5A: g = {8'h61, 8'h51, 8'h49, 8'h45, 8'h43};
            8'h2D: g = {8'h00, 8'h08, 8'h08, 8'h08, 8'h00};
            8'h2E: g = {8'h00, 8'h00, 8'h60, 8'h00, 8'h00};
            8'h3A: g = {8'h00, 8'h00, 8'h36, 8'h00, 8'h00};
            8'h2F: g = {8'h20, 8'h10, 8'h08, 8'h04, 8'h02};
            8'h21: g = {8'h00, 8'h00, 8'h5F, 8'h00, 8'h00};
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

// File: src/trgr_front.sv
// Front end: accepts items, tracks the column position and queues characters that fit.
`default_nettype none

module trgr_front (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic                i_kind,
    input  wire logic [7:0]          i_char_code,
    output logic                     o_in_stall,
    input  wire trgr_pkg::t_fifo_stat i_fifo_stat,
    output logic                     o_push,
    output trgr_pkg::t_entry         o_entry
);
    import trgr_pkg::*;

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic             accept;
    logic             fits;
    logic [POS_W:0]   pos_end;

    assign o_in_stall = i_fifo_stat.full;
    assign accept     = i_in_valid && !i_fifo_stat.full;
    assign pos_end    = {1'b0, r_pos} + (POS_W+1)'(CELL_COLS);
    assign fits       = pos_end <= (POS_W+1)'(ROW_WIDTH);
    assign o_push     = accept && (i_kind == 1'(KIND_CHAR)) && fits;

    assign o_entry.base = r_pos[IDX_W-1:0];
    assign o_entry.cols = font_lookup(i_char_code);

    always_comb begin
        n_pos = r_pos;
        if (accept) begin
            if (i_kind == 1'(KIND_NEWLINE)) begin
                n_pos = '0;
            end else if (fits) begin
                n_pos = pos_end[POS_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

`ifndef SYNTHESIS
    a_pos_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_pos} <= (POS_W+1)'(ROW_WIDTH))
        else $error("column position beyond row width");
    a_newline_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_kind == 1'(KIND_NEWLINE)) |=> (r_pos == '0))
        else $error("new line did not clear position");
    a_push_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> (r_pos == POS_W'($past(r_pos) + POS_W'(CELL_COLS))))
        else $error("position did not advance by one cell");
`endif

endmodule

`default_nettype wire

// File: src/trgr_fifo.sv
// Two-entry queue between the front end and the column sequencer.
`default_nettype none

module trgr_fifo (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire trgr_pkg::t_entry     i_entry,
    input  wire logic                 i_pop,
    output trgr_pkg::t_entry          o_head,
    output trgr_pkg::t_fifo_stat      o_stat
);
    import trgr_pkg::*;

    t_entry     r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.full  = r_count == 2'd2;
    assign o_stat.empty = r_count == 2'd0;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_stat.full)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("pop from empty queue");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

// File: src/trgr_back.sv
// Back end: walks the six columns of the queued character into the output register.
`default_nettype none

module trgr_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire trgr_pkg::t_fifo_stat i_fifo_stat,
    input  wire trgr_pkg::t_entry     i_head,
    output logic                      o_pop,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [6:0]                o_column_index,
    output logic [7:0]                o_column_bits,
    output logic                      o_last
);
    import trgr_pkg::*;

    logic [CNT_W-1:0] r_cnt;
    logic             r_out_valid;
    logic [IDX_W-1:0] r_column_index;
    logic [7:0]       r_column_bits;
    logic             r_last;
    logic             load;
    logic             take;
    logic             spacer;

    assign load   = !r_out_valid || !i_out_stall;
    assign take   = load && !i_fifo_stat.empty;
    assign spacer = r_cnt == CNT_W'(CELL_COLS - 1);
    assign o_pop  = take && spacer;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= take;
            if (take) begin
                r_cnt <= spacer ? '0 : r_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_column_index <= i_head.base + IDX_W'(r_cnt);
            r_column_bits  <= spacer ? 8'h00 : i_head.cols[r_cnt];
            r_last         <= spacer;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_column_index = r_column_index;
    assign o_column_bits  = r_column_bits;
    assign o_last         = r_last;

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(CELL_COLS - 1))
        else $error("column counter out of range");
    a_spacer_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last) |-> (o_column_bits == 8'h00))
        else $error("spacer column not blank");
    a_columns_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_last) |=>
            (o_out_valid && o_column_index == IDX_W'($past(o_column_index) + IDX_W'(1))))
        else $error("columns of one character not contiguous");
`endif

endmodule

`default_nettype wire

// File: src/text_row_glyph_renderer.sv
// Top level of the text row glyph renderer: front end, queue and column sequencer.
//
// Input channel (i_in_valid / o_in_stall): one transaction carries i_kind and
// i_char_code. A character gives six output transactions: five font columns and a
// blank spacer with o_last set, at consecutive column indices from the running
// position. A new line resets the position and gives nothing; a character that
// would run past the row is dropped and gives nothing.
// Output channel (o_out_valid / i_out_stall): one column byte per transaction.
// The first column of an accepted character passes through the queue entry and then
// the output register when the sequencer is free.
// Throughput: the column sequencer emits one column per cycle while a character waits
// and the receiver does not stall; the two-entry queue holds the character being walked
// and the next one; the front end never queues new lines or dropped characters.
// o_in_stall rises only while the two-entry queue is full. When the receiver
// stalls, the output register holds its column and the queue fills behind it.
// Synchronous reset clears the position to zero and empties the queue and output.
`default_nettype none

module text_row_glyph_renderer (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic       i_kind,
    input  wire logic [7:0] i_char_code,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [6:0]      o_column_index,
    output logic [7:0]      o_column_bits,
    output logic            o_last
);
    import trgr_pkg::*;

    t_fifo_stat fifo_stat;
    t_entry     push_entry;
    t_entry     head;
    logic       push;
    logic       pop;

    trgr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_kind      (i_kind),
        .i_char_code (i_char_code),
        .o_in_stall  (o_in_stall),
        .i_fifo_stat (fifo_stat),
        .o_push      (push),
        .o_entry     (push_entry)
    );

    trgr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (fifo_stat)
    );

    trgr_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fifo_stat    (fifo_stat),
        .i_head         (head),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_column_index (o_column_index),
        .o_column_bits  (o_column_bits),
        .o_last         (o_last)
    );

endmodule

`default_nettype wire
